@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmc_pkg
// Types and constants shared by the button mode counter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmc_pkg;

    // Bit positions in the mode flag register.
    localparam int unsigned FLAG_INV_INP  = 0;
    localparam int unsigned FLAG_INV_EN   = 1;
    localparam int unsigned FLAG_BINARY   = 2;
    localparam int unsigned FLAG_LONG_RST = 3;
    localparam int unsigned FLAG_UPDOWN   = 4;
    localparam int unsigned FLAG_ROTATE   = 5;
    localparam int unsigned FLAG_PINGPONG = 6;
    localparam int unsigned FLAG_SKIP0    = 7;
    localparam int unsigned FLAG_RANDOM   = 8;
    localparam int unsigned FLAG_LOCALVAR = 9;
    localparam int unsigned FLAG_NOOUT    = 10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE_FLAGS    = 2'd0;
    localparam logic [1:0] CFG_DEST_COUNT    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Button state codes.
    localparam logic [1:0] BTN_ON        = 2'd1;
    localparam logic [1:0] BTN_TURNED_ON = 2'd3;

    // Counter constants: reverse flag, clean mask, reverse bottom with skip zero.
    localparam logic [7:0] REV_FLAG     = 8'h80;
    localparam logic [7:0] CLEAN_MASK   = 8'h7F;
    localparam logic [7:0] REV_BOTTOM_1 = 8'h81;

    // Hold time for a long press, in 16 ms ticks.
    localparam logic [15:0] LONG_TICKS = 16'(1500 / 16);

    // Widest binary output in bits.
    localparam logic [4:0] BINARY_MAX_BITS = 5'd7;

    // Reset value of the destination count.
    localparam logic [4:0] DEST_COUNT_RESET = 5'd2;

    typedef struct packed {
        logic [10:0] mode_flags;
        logic [4:0]  dest_count;
        logic [15:0] timeout_ticks;
    } bmc_cfg_t;

    typedef struct packed {
        logic [1:0]  trigger_state;
        logic [1:0]  enable_state;
        logic [15:0] time_now;
        logic [7:0]  random_byte;
        logic        init;
    } bmc_item_t;

    typedef struct packed {
        logic [6:0]  count_value;
        logic [15:0] pattern;
        logic        pattern_update;
        logic        var_update;
    } bmc_result_t;

endpackage

@@ src/bmc_step.sv @@
// ----------------------------------------------------------------------------
// bmc_step
// Combinational update of the counter and press time for one evaluation tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmc_step #(
    parameter int MAX_OUTPUTS = 16
) (
    input  bmc_pkg::bmc_cfg_t    cfg,
    input  bmc_pkg::bmc_item_t   item,
    input  logic [7:0]           count_cur,
    input  logic [15:0]          last_cur,
    output logic [7:0]           count_new,
    output logic [15:0]          last_new,
    output bmc_pkg::bmc_result_t result
);

    localparam logic [5:0] MaxN = 6'(MAX_OUTPUTS);

    logic [5:0]  n;
    logic [7:0]  top;
    logic [1:0]  trig;
    logic [1:0]  en;
    logic [7:0]  c;
    logic [7:0]  lo;
    logic [7:0]  span;
    logic [15:0] prod;
    logic [15:0] press_age;
    logic        rotate;
    logic        skip0;
    logic        rot_only;
    logic        rot_skip;
    logic        force_upd;
    logic        changed;
    logic [7:0]  clean;
    logic [15:0] pat;

    // Count range from the destination count.
    always_comb
    begin
        if (cfg.mode_flags[bmc_pkg::FLAG_BINARY])
        begin
            if (cfg.dest_count == 5'd0)
                n = 6'd1;
            else if (cfg.dest_count > bmc_pkg::BINARY_MAX_BITS)
                n = {1'b0, bmc_pkg::BINARY_MAX_BITS};
            else
                n = {1'b0, cfg.dest_count};
            top = (8'd1 << n[2:0]) - 8'd1;
        end
        else
        begin
            if (cfg.dest_count == 5'd0)
                n = 6'd1;
            else if ({1'b0, cfg.dest_count} > MaxN)
                n = MaxN;
            else
                n = {1'b0, cfg.dest_count};
            top = {2'b00, n} - 8'd1;
        end
    end

    assign rotate   = cfg.mode_flags[bmc_pkg::FLAG_ROTATE];
    assign skip0    = cfg.mode_flags[bmc_pkg::FLAG_SKIP0];
    assign rot_only = rotate && !skip0;
    assign rot_skip = rotate && skip0;

    // Random pick scaled into the allowed range.
    assign lo   = skip0 ? 8'd1 : 8'd0;
    assign span = top + 8'd1 - lo;
    assign prod = item.random_byte * span;

    // Counter update for the trigger, the enable button, the long-press reset and the timeout.
    always_comb
    begin
        trig      = item.trigger_state ^ {1'b0, cfg.mode_flags[bmc_pkg::FLAG_INV_INP]};
        en        = item.enable_state ^ {1'b0, cfg.mode_flags[bmc_pkg::FLAG_INV_EN]};
        c         = count_cur;
        last_new  = last_cur;
        force_upd = item.init;
        press_age = item.time_now - last_cur;

        if (!cfg.mode_flags[bmc_pkg::FLAG_UPDOWN] && !en[0])
        begin
            c = 8'd0;
        end
        else
        begin
            if (trig == bmc_pkg::BTN_TURNED_ON)
            begin
                if (cfg.mode_flags[bmc_pkg::FLAG_PINGPONG])
                begin
                    if (c == top)
                        c = (top - 8'd1) | bmc_pkg::REV_FLAG;
                    else if (!skip0 && c == bmc_pkg::REV_FLAG)
                        c = 8'd1;
                    else if (skip0 && c == bmc_pkg::REV_BOTTOM_1)
                        c = 8'd2;
                    else if ((c & bmc_pkg::REV_FLAG) != 8'd0)
                        c = c - 8'd1;
                    else
                        c = c + 8'd1;
                end
                else if (cfg.mode_flags[bmc_pkg::FLAG_RANDOM])
                begin
                    c         = lo + prod[15:8];
                    force_upd = 1'b1;
                end
                else if (c == top)
                begin
                    if (rot_skip)
                        c = 8'd1;
                    else if (rot_only)
                        c = 8'd0;
                end
                else
                begin
                    c = c + 8'd1;
                end
                last_new = item.time_now;
            end
            else if (trig == bmc_pkg::BTN_ON)
            begin
                if (cfg.mode_flags[bmc_pkg::FLAG_LONG_RST] && press_age >= bmc_pkg::LONG_TICKS)
                    c = 8'd0;
            end

            // Down step in up/down mode.
            if (cfg.mode_flags[bmc_pkg::FLAG_UPDOWN] && en == bmc_pkg::BTN_TURNED_ON)
            begin
                if ((rot_only && c == 8'd0) || (rot_skip && c <= 8'd1))
                    c = top;
                else if (c > 8'd0)
                    c = c - 8'd1;
                last_new = item.time_now;
            end

            // Inactivity timeout, measured from the latest press.
            if (cfg.timeout_ticks != 16'd0 && c != 8'd0 &&
                (16'(item.time_now - last_new)) >= cfg.timeout_ticks)
                c = 8'd0;
        end
    end

    assign count_new = c;
    assign changed   = force_upd || (count_cur != c);
    assign clean     = cfg.mode_flags[bmc_pkg::FLAG_PINGPONG] ? (c & bmc_pkg::CLEAN_MASK) : c;

    // Output pattern, only when an update is reported.
    always_comb
    begin
        pat = 16'd0;
        if (changed && !cfg.mode_flags[bmc_pkg::FLAG_NOOUT])
        begin
            if (cfg.mode_flags[bmc_pkg::FLAG_BINARY])
                pat = {8'h00, clean & top};
            else if ({2'b00, n} > clean && clean < 8'd16)
                pat = 16'd1 << clean[3:0];
        end
    end

    assign result.count_value    = clean[6:0];
    assign result.pattern        = pat;
    assign result.pattern_update = changed && !cfg.mode_flags[bmc_pkg::FLAG_NOOUT];
    assign result.var_update     = changed && cfg.mode_flags[bmc_pkg::FLAG_LOCALVAR];

endmodule

@@ src/button_mode_counter.sv @@
// ----------------------------------------------------------------------------
// button_mode_counter
// Button-driven 8-bit mode counter with one-hot or binary output pattern.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   trigger_state, enable_state, time_now,
//                                  random_byte, init
//  output    out_valid / out_stall count_value, pattern, pattern_update,
//                                  var_update
//  config    cfg_we                cfg_index, cfg_data
//
// A request is latched in the input register, then evaluated combinationally
// into the result register; one request per cycle while the output is not stalled.
// The counter and press time update when a request moves to the result
// register, so the next request sees them at once.
// A stalled result holds; the input register still takes one more request.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module button_mode_counter #(
    parameter int MAX_OUTPUTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  trigger_state,
    input  logic [1:0]  enable_state,
    input  logic [15:0] time_now,
    input  logic [7:0]  random_byte,
    input  logic        init,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  count_value,
    output logic [15:0] pattern,
    output logic        pattern_update,
    output logic        var_update
);

    bmc_pkg::bmc_cfg_t    cfg;
    bmc_pkg::bmc_item_t   item_reg;
    bmc_pkg::bmc_result_t result_reg;
    bmc_pkg::bmc_result_t step_result;

    logic [10:0] mode_flags_reg;
    logic [4:0]  dest_count_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [15:0] last_press_reg;
    logic [15:0] last_press_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_accept;
    logic        s1_fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_flags_reg    <= 11'd0;
            dest_count_reg    <= bmc_pkg::DEST_COUNT_RESET;
            timeout_ticks_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmc_pkg::CFG_MODE_FLAGS:    mode_flags_reg    <= cfg_data[10:0];
                bmc_pkg::CFG_DEST_COUNT:    dest_count_reg    <= cfg_data[4:0];
                bmc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign cfg.mode_flags    = mode_flags_reg;
    assign cfg.dest_count    = dest_count_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

    // Handshake: the input register moves on when the result register is empty or its result is taken.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !(!out_valid_reg || !out_stall);
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    // Evaluation of the latched request.
    bmc_step #(
        .MAX_OUTPUTS(MAX_OUTPUTS)
    ) u_step (
        .cfg       (cfg),
        .item      (item_reg),
        .count_cur (count_reg),
        .last_cur  (last_press_reg),
        .count_new (count_next),
        .last_new  (last_press_next),
        .result    (step_result)
    );

    // Control and counter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= 8'd0;
            last_press_reg <= 16'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                count_reg      <= count_next;
                last_press_reg <= last_press_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.trigger_state <= trigger_state;
            item_reg.enable_state  <= enable_state;
            item_reg.time_now      <= time_now;
            item_reg.random_byte   <= random_byte;
            item_reg.init          <= init;
        end
        if (s1_fire)
            result_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign count_value    = result_reg.count_value;
    assign pattern        = result_reg.pattern;
    assign pattern_update = result_reg.pattern_update;
    assign var_update     = result_reg.var_update;

    // Checks on the pipeline control.
    `ASSERT_ALWAYS(a_stall_needs_s1, clk, rst_n, !in_stall || s1_valid_reg, "input stalled with empty input register")
    `ASSERT_NEXT(a_count_holds, clk, rst_n, !s1_fire, $stable(count_reg) && $stable(last_press_reg), "counter state changed without an evaluated request")
    `ASSERT_ALWAYS(a_pattern_quiet, clk, rst_n, !out_valid_reg || pattern_update || (pattern == 16'd0), "pattern set without pattern update")

endmodule
